// File: hdl/ccpt_pkg.sv
// ----------------------------------------------------------------------------
// ccpt_pkg: shared types and constants of the collider pair contact test
// Widths of the fixed-point datapath, shape and mode codes, register
// indexes, the context record carried down the pipeline, least-axis pick.
// ----------------------------------------------------------------------------
package ccpt_pkg;

   localparam int COORD_W    = 32;
   localparam int HALF_W     = 31;
   localparam int DEPTH_W    = 32;
   localparam int NORM_W     = 18;
   localparam int QUO_W      = 17;
   localparam int DELTA_W    = 33;
   localparam int OVL_W      = 34;
   localparam int MAG_W      = 32;
   localparam int SQ_W       = 64;
   localparam int SUM_W      = 66;
   localparam int ROOT_W     = 32;
   localparam int REM_W      = 34;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int AXES       = 3;

   localparam logic SHAPE_BOX    = 1'b0;
   localparam logic SHAPE_SPHERE = 1'b1;

   localparam logic [NORM_W-1:0] NORM_POS = NORM_W'(65536);
   localparam logic [NORM_W-1:0] NORM_NEG = NORM_W'(-65536);

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   typedef enum logic [1:0] {
      MODE_BOX_BOX,
      MODE_SPH_SPH,
      MODE_SPH_BOX,
      MODE_BOX_SPH
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SHAPE,
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_CENTER_Z,
      CSR_HALF_X,
      CSR_HALF_Y,
      CSR_HALF_Z,
      CSR_RADIUS
   } csr_index_type;

   typedef struct packed {
      mode_type                   mode;
      logic                       bb_hit;
      axis_type                   bb_axis;
      logic                       bb_neg;
      logic [DEPTH_W-1:0]         bb_depth;
      axis_type                   in_axis;
      logic                       in_neg;
      logic [DEPTH_W-1:0]         in_depth;
      logic                       sph_hit;
      logic                       s_zero;
      logic [AXES-1:0]            sgn;
      logic [AXES-1:0][MAG_W-1:0] mag;
      logic [MAG_W-1:0]           rad;
   } ctx_type;

   function automatic axis_type least_axis(input logic [OVL_W-1:0] a,
                                           input logic [OVL_W-1:0] b,
                                           input logic [OVL_W-1:0] c);
      axis_type         k;
      logic [OVL_W-1:0] best;
      k    = AXIS_X;
      best = a;
      if ($signed(b) < $signed(best)) begin
         k    = AXIS_Y;
         best = b;
      end
      if ($signed(c) < $signed(best)) begin
         k = AXIS_Z;
      end
      return k;
   endfunction

endpackage

// File: hdl/ccpt_isqrt.sv
// ----------------------------------------------------------------------------
// ccpt_isqrt: pipelined integer square root
// Two radicand bits per stage, one root bit per stage; context rides along.
// ----------------------------------------------------------------------------
module ccpt_isqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [ccpt_pkg::SQ_W-1:0] in_rad,
   input  ccpt_pkg::ctx_type        in_ctx,
   output logic                     out_valid,
   output logic [ccpt_pkg::ROOT_W-1:0] out_root,
   output ccpt_pkg::ctx_type        out_ctx
);
   import ccpt_pkg::*;

   localparam int STEPS = ROOT_W;

   logic [STEPS-1:0]  valid_ff;
   logic [SQ_W-1:0]   rad_ff  [STEPS];
   logic [REM_W-1:0]  rem_ff  [STEPS];
   logic [ROOT_W-1:0] root_ff [STEPS];
   ctx_type           ctx_ff  [STEPS];

   logic [STEPS-1:0]  valid_in;
   logic [SQ_W-1:0]   rad_in  [STEPS];
   logic [REM_W-1:0]  rem_in  [STEPS];
   logic [ROOT_W-1:0] root_in [STEPS];
   ctx_type           ctx_in  [STEPS];

   always_comb begin
      logic [SQ_W-1:0]   prad;
      logic [REM_W-1:0]  prem;
      logic [ROOT_W-1:0] proot;
      logic [REM_W+1:0]  rem_sh;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  diff;
      logic              ge;
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            valid_in[k] = in_valid;
            prad        = in_rad;
            prem        = '0;
            proot       = '0;
            ctx_in[k]   = in_ctx;
         end else begin
            valid_in[k] = valid_ff[k-1];
            prad        = rad_ff[k-1];
            prem        = rem_ff[k-1];
            proot       = root_ff[k-1];
            ctx_in[k]   = ctx_ff[k-1];
         end
         rem_sh     = {prem, prad[SQ_W-1 -: 2]};
         trial      = {2'b00, proot, 2'b01};
         diff       = rem_sh - trial;
         ge         = (rem_sh >= trial);
         rad_in[k]  = {prad[SQ_W-3:0], 2'b00};
         rem_in[k]  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_in[k] = {proot[ROOT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STEPS; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            ctx_ff[k]  <= ctx_in[k];
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_ctx   = ctx_ff[STEPS-1];

endmodule

// File: hdl/ccpt_ndiv.sv
// ----------------------------------------------------------------------------
// ccpt_ndiv: pipelined normal divider, three lanes
// Quotient of num * 2^16 / den for num <= den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ccpt_ndiv (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            en,
   input  logic                                            in_valid,
   input  logic [ccpt_pkg::AXES-1:0][ccpt_pkg::MAG_W-1:0]  in_num,
   input  logic [ccpt_pkg::ROOT_W-1:0]                     in_den,
   input  ccpt_pkg::ctx_type                               in_ctx,
   output logic                                            out_valid,
   output logic [ccpt_pkg::AXES-1:0][ccpt_pkg::QUO_W-1:0]  out_quo,
   output logic [ccpt_pkg::ROOT_W-1:0]                     out_den,
   output ccpt_pkg::ctx_type                               out_ctx
);
   import ccpt_pkg::*;

   localparam int STEPS = QUO_W;

   logic [STEPS-1:0]                 valid_ff;
   logic [AXES-1:0][MAG_W-1:0]       rem_ff [STEPS];
   logic [AXES-1:0][QUO_W-1:0]       quo_ff [STEPS];
   logic [ROOT_W-1:0]                den_ff [STEPS];
   ctx_type                          ctx_ff [STEPS];

   logic [STEPS-1:0]                 valid_in;
   logic [AXES-1:0][MAG_W-1:0]       rem_in [STEPS];
   logic [AXES-1:0][QUO_W-1:0]       quo_in [STEPS];
   logic [ROOT_W-1:0]                den_in [STEPS];
   ctx_type                          ctx_in [STEPS];

   always_comb begin
      logic [AXES-1:0][MAG_W-1:0] prem;
      logic [AXES-1:0][QUO_W-1:0] pquo;
      logic [MAG_W:0]             rem_sh;
      logic [MAG_W:0]             diff;
      logic                       ge;
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            valid_in[k] = in_valid;
            prem        = in_num;
            pquo        = '0;
            den_in[k]   = in_den;
            ctx_in[k]   = in_ctx;
         end else begin
            valid_in[k] = valid_ff[k-1];
            prem        = rem_ff[k-1];
            pquo        = quo_ff[k-1];
            den_in[k]   = den_ff[k-1];
            ctx_in[k]   = ctx_ff[k-1];
         end
         for (int l = 0; l < AXES; l++) begin
            if (k == 0) begin
               rem_sh = {1'b0, prem[l]};
            end else begin
               rem_sh = {prem[l], 1'b0};
            end
            diff            = rem_sh - {1'b0, den_in[k]};
            ge              = (rem_sh >= {1'b0, den_in[k]});
            rem_in[k][l]    = ge ? diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
            quo_in[k][l]    = {pquo[l][QUO_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_in[k];
            ctx_ff[k] <= ctx_in[k];
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_den   = den_ff[STEPS-1];
   assign out_ctx   = ctx_ff[STEPS-1];

endmodule

// File: hdl/collider_pair_contact_test.sv
// ----------------------------------------------------------------------------
// collider_pair_contact_test: narrow-phase box/sphere contact test
// 55 register stages from a request transfer to its response being offered: 5 front
// stages, 32-stage square root, 17-stage divider, response register. Throughput: one
// transfer per cycle, every stage pipelined.
// The whole pipeline holds while a response is refused.
// Reset: synchronous; clears all valid bits and the reference registers to 0.
// ----------------------------------------------------------------------------
module collider_pair_contact_test (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccpt_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [ccpt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_other_shape,
   input  logic [ccpt_pkg::COORD_W-1:0]      req_other_center_x,
   input  logic [ccpt_pkg::COORD_W-1:0]      req_other_center_y,
   input  logic [ccpt_pkg::COORD_W-1:0]      req_other_center_z,
   input  logic [ccpt_pkg::HALF_W-1:0]       req_other_half_x,
   input  logic [ccpt_pkg::HALF_W-1:0]       req_other_half_y,
   input  logic [ccpt_pkg::HALF_W-1:0]       req_other_half_z,
   input  logic [ccpt_pkg::HALF_W-1:0]       req_other_radius,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [ccpt_pkg::NORM_W-1:0]       rsp_normal_x,
   output logic [ccpt_pkg::NORM_W-1:0]       rsp_normal_y,
   output logic [ccpt_pkg::NORM_W-1:0]       rsp_normal_z,
   output logic [ccpt_pkg::DEPTH_W-1:0]      rsp_depth
);
   import ccpt_pkg::*;

   // reference collider registers
   logic                               ref_shape_ff;
   logic [AXES-1:0][COORD_W-1:0]       ref_center_ff;
   logic [AXES-1:0][HALF_W-1:0]        ref_half_ff;
   logic [HALF_W-1:0]                  ref_radius_ff;

   logic en;

   // stage 1
   logic                               valid_s1_ff;
   mode_type                           mode_s1_ff, mode_in;
   logic [AXES-1:0][DELTA_W-1:0]       dl_s1_ff, dl_in;
   logic [AXES-1:0][MAG_W-1:0]         hs_s1_ff, hs_in;
   logic [AXES-1:0][HALF_W-1:0]        bh_s1_ff, bh_in;
   logic [MAG_W-1:0]                   rad_s1_ff, rad_in;

   // stage 2
   logic                               valid_s2_ff;
   mode_type                           mode_s2_ff;
   logic [MAG_W-1:0]                   rad_s2_ff;
   logic [AXES-1:0]                    sgn_s2_ff, sgn_in;
   logic [OVL_W-1:0]                   ov_s2_ff [AXES];
   logic [OVL_W-1:0]                   ov_in [AXES];
   logic [OVL_W-1:0]                   ovi_s2_ff [AXES];
   logic [OVL_W-1:0]                   ovi_in [AXES];
   logic [AXES-1:0][MAG_W-1:0]         m_s2_ff, m_in;

   // stage 3
   logic                               valid_s3_ff;
   ctx_type                            ctx_s3_ff, ctx3_in;
   logic                               big_s3_ff, big_in;
   logic [AXES-1:0][SQ_W-1:0]          sq_s3_ff, sq_in;
   logic [SQ_W-1:0]                    thr_s3_ff, thr_in;

   // stage 4
   logic                               valid_s4_ff;
   ctx_type                            ctx_s4_ff;
   logic                               big_s4_ff;
   logic [SUM_W-1:0]                   sum_s4_ff, sum_in;
   logic [SQ_W-1:0]                    thr_s4_ff;

   // stage 5
   logic                               valid_s5_ff;
   ctx_type                            ctx_s5_ff, ctx5_in;
   logic [SQ_W-1:0]                    rad_s5_ff;

   // square root and divider
   logic                               sq_valid;
   logic [ROOT_W-1:0]                  sq_root;
   ctx_type                            sq_ctx;
   logic                               dv_valid;
   logic [AXES-1:0][QUO_W-1:0]         dv_quo;
   logic [ROOT_W-1:0]                  dv_den;
   ctx_type                            dv_ctx;

   // response register
   logic                               rsp_valid_ff;
   logic                               rsp_hit_ff, hit_in;
   logic [AXES-1:0][NORM_W-1:0]        rsp_normal_ff, nrm_in;
   logic [DEPTH_W-1:0]                 rsp_depth_ff, depth_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_shape_ff  <= SHAPE_BOX;
         ref_center_ff <= '0;
         ref_half_ff   <= '0;
         ref_radius_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SHAPE:    ref_shape_ff     <= csr_wdata[0];
            CSR_CENTER_X: ref_center_ff[0] <= csr_wdata;
            CSR_CENTER_Y: ref_center_ff[1] <= csr_wdata;
            CSR_CENTER_Z: ref_center_ff[2] <= csr_wdata;
            CSR_HALF_X:   ref_half_ff[0]   <= csr_wdata[HALF_W-1:0];
            CSR_HALF_Y:   ref_half_ff[1]   <= csr_wdata[HALF_W-1:0];
            CSR_HALF_Z:   ref_half_ff[2]   <= csr_wdata[HALF_W-1:0];
            CSR_RADIUS:   ref_radius_ff    <= csr_wdata[HALF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // stage 1: deltas, half sums, radius selection
   always_comb begin
      logic [AXES-1:0][COORD_W-1:0] oc;
      logic [AXES-1:0][HALF_W-1:0]  oh;
      oc = {req_other_center_z, req_other_center_y, req_other_center_x};
      oh = {req_other_half_z, req_other_half_y, req_other_half_x};
      if (ref_shape_ff == SHAPE_BOX && req_other_shape == SHAPE_BOX) begin
         mode_in = MODE_BOX_BOX;
      end else if (ref_shape_ff == SHAPE_SPHERE && req_other_shape == SHAPE_SPHERE) begin
         mode_in = MODE_SPH_SPH;
      end else if (ref_shape_ff == SHAPE_SPHERE) begin
         mode_in = MODE_SPH_BOX;
      end else begin
         mode_in = MODE_BOX_SPH;
      end
      for (int i = 0; i < AXES; i++) begin
         if (mode_in == MODE_SPH_BOX) begin
            dl_in[i] = {ref_center_ff[i][COORD_W-1], ref_center_ff[i]}
                     - {oc[i][COORD_W-1], oc[i]};
            bh_in[i] = oh[i];
         end else begin
            dl_in[i] = {oc[i][COORD_W-1], oc[i]}
                     - {ref_center_ff[i][COORD_W-1], ref_center_ff[i]};
            bh_in[i] = ref_half_ff[i];
         end
         hs_in[i] = {1'b0, ref_half_ff[i]} + {1'b0, oh[i]};
      end
      case (mode_in)
         MODE_SPH_SPH: rad_in = {1'b0, ref_radius_ff} + {1'b0, req_other_radius};
         MODE_SPH_BOX: rad_in = {1'b0, ref_radius_ff};
         MODE_BOX_SPH: rad_in = {1'b0, req_other_radius};
         default:      rad_in = '0;
      endcase
   end

   // stage 2: magnitudes, overlaps, clamp distances
   always_comb begin
      logic [DELTA_W-1:0] mag;
      logic [MAG_W-1:0]   mag32;
      logic [MAG_W-1:0]   vmag;
      for (int i = 0; i < AXES; i++) begin
         sgn_in[i] = dl_s1_ff[i][DELTA_W-1];
         mag       = sgn_in[i] ? (DELTA_W'(0) - dl_s1_ff[i]) : dl_s1_ff[i];
         mag32     = mag[MAG_W-1:0];
         ov_in[i]  = {2'b00, hs_s1_ff[i]} - {1'b0, mag};
         ovi_in[i] = {3'b000, bh_s1_ff[i]} + {2'b00, rad_s1_ff} - {1'b0, mag};
         vmag      = (mag32 > {1'b0, bh_s1_ff[i]}) ? (mag32 - {1'b0, bh_s1_ff[i]}) : '0;
         m_in[i]   = (mode_s1_ff == MODE_SPH_SPH) ? mag32 : vmag;
      end
   end

   // stage 3: box decisions, squares
   always_comb begin
      axis_type bb_k;
      axis_type in_k;
      bb_k = least_axis(ov_s2_ff[0], ov_s2_ff[1], ov_s2_ff[2]);
      in_k = least_axis(ovi_s2_ff[0], ovi_s2_ff[1], ovi_s2_ff[2]);
      ctx3_in          = '0;
      ctx3_in.mode     = mode_s2_ff;
      ctx3_in.bb_hit   = ($signed(ov_s2_ff[0]) > 0) && ($signed(ov_s2_ff[1]) > 0)
                       && ($signed(ov_s2_ff[2]) > 0);
      ctx3_in.bb_axis  = bb_k;
      ctx3_in.bb_neg   = sgn_s2_ff[bb_k];
      ctx3_in.bb_depth = ov_s2_ff[bb_k][DEPTH_W-1:0];
      ctx3_in.in_axis  = in_k;
      ctx3_in.in_neg   = sgn_s2_ff[in_k];
      ctx3_in.in_depth = ovi_s2_ff[in_k][DEPTH_W-1:0];
      ctx3_in.sgn      = sgn_s2_ff;
      ctx3_in.mag      = m_s2_ff;
      ctx3_in.rad      = rad_s2_ff;
      big_in = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         if (m_s2_ff[i] > rad_s2_ff) begin
            big_in = 1'b1;
         end
         sq_in[i] = SQ_W'(m_s2_ff[i]) * SQ_W'(m_s2_ff[i]);
      end
      thr_in = SQ_W'(rad_s2_ff) * SQ_W'(rad_s2_ff);
   end

   // stage 4: squared distance
   assign sum_in = SUM_W'(sq_s3_ff[0]) + SUM_W'(sq_s3_ff[1]) + SUM_W'(sq_s3_ff[2]);

   // stage 5: sphere hit decision
   always_comb begin
      ctx5_in        = ctx_s4_ff;
      ctx5_in.s_zero = (sum_s4_ff == '0);
      case (ctx_s4_ff.mode)
         MODE_SPH_SPH: ctx5_in.sph_hit = (sum_s4_ff < SUM_W'(thr_s4_ff));
         MODE_SPH_BOX,
         MODE_BOX_SPH: ctx5_in.sph_hit = !big_s4_ff && (sum_s4_ff <= SUM_W'(thr_s4_ff));
         default:      ctx5_in.sph_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
         valid_s3_ff <= 1'b0;
         valid_s4_ff <= 1'b0;
         valid_s5_ff <= 1'b0;
      end else if (en) begin
         valid_s1_ff <= req_valid;
         valid_s2_ff <= valid_s1_ff;
         valid_s3_ff <= valid_s2_ff;
         valid_s4_ff <= valid_s3_ff;
         valid_s5_ff <= valid_s4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode_s1_ff <= mode_in;
         dl_s1_ff   <= dl_in;
         hs_s1_ff   <= hs_in;
         bh_s1_ff   <= bh_in;
         rad_s1_ff  <= rad_in;
         mode_s2_ff <= mode_s1_ff;
         rad_s2_ff  <= rad_s1_ff;
         sgn_s2_ff  <= sgn_in;
         ov_s2_ff   <= ov_in;
         ovi_s2_ff  <= ovi_in;
         m_s2_ff    <= m_in;
         ctx_s3_ff  <= ctx3_in;
         big_s3_ff  <= big_in;
         sq_s3_ff   <= sq_in;
         thr_s3_ff  <= thr_in;
         ctx_s4_ff  <= ctx_s3_ff;
         big_s4_ff  <= big_s3_ff;
         sum_s4_ff  <= sum_in;
         thr_s4_ff  <= thr_s3_ff;
         ctx_s5_ff  <= ctx5_in;
         rad_s5_ff  <= sum_s4_ff[SQ_W-1:0];
      end
   end

   ccpt_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_s5_ff),
      .in_rad    (rad_s5_ff),
      .in_ctx    (ctx_s5_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_ctx   (sq_ctx)
   );

   ccpt_ndiv u_ndiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_num    (sq_ctx.mag),
      .in_den    (sq_root),
      .in_ctx    (sq_ctx),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_den   (dv_den),
      .out_ctx   (dv_ctx)
   );

   // result assembly
   always_comb begin
      logic [NORM_W-1:0] q;
      logic              flip;
      hit_in   = 1'b0;
      nrm_in   = '0;
      depth_in = '0;
      case (dv_ctx.mode)
         MODE_BOX_BOX: begin
            hit_in = dv_ctx.bb_hit;
            if (dv_ctx.bb_hit) begin
               nrm_in[dv_ctx.bb_axis] = dv_ctx.bb_neg ? NORM_NEG : NORM_POS;
               depth_in               = dv_ctx.bb_depth;
            end
         end
         default: begin
            hit_in = dv_ctx.sph_hit;
            if (dv_ctx.sph_hit) begin
               if (dv_ctx.s_zero && dv_ctx.mode == MODE_SPH_SPH) begin
                  nrm_in[AXIS_X] = NORM_POS;
                  depth_in       = dv_ctx.rad;
               end else if (dv_ctx.s_zero) begin
                  nrm_in[dv_ctx.in_axis] = ((dv_ctx.mode == MODE_BOX_SPH) ^ dv_ctx.in_neg)
                                         ? NORM_POS : NORM_NEG;
                  depth_in               = dv_ctx.in_depth;
               end else begin
                  for (int i = 0; i < AXES; i++) begin
                     q         = {1'b0, dv_quo[i]};
                     flip      = dv_ctx.sgn[i] ^ (dv_ctx.mode == MODE_SPH_BOX);
                     nrm_in[i] = flip ? (NORM_W'(0) - q) : q;
                  end
                  depth_in = dv_ctx.rad - dv_den;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff    <= hit_in;
         rsp_normal_ff <= nrm_in;
         rsp_depth_ff  <= depth_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_normal_x = rsp_normal_ff[0];
   assign rsp_normal_y = rsp_normal_ff[1];
   assign rsp_normal_z = rsp_normal_ff[2];
   assign rsp_depth    = rsp_depth_ff;

   a_miss_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_normal_ff == '0 && rsp_depth == '0)
      else $error("miss carries a normal or depth");

   a_hit_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_normal_ff != '0)
      else $error("hit without a normal");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_normal_x) <= $signed(NORM_POS)
         && $signed(rsp_normal_x) >= $signed(NORM_NEG)
         && $signed(rsp_normal_y) <= $signed(NORM_POS)
         && $signed(rsp_normal_y) >= $signed(NORM_NEG)
         && $signed(rsp_normal_z) <= $signed(NORM_POS)
         && $signed(rsp_normal_z) >= $signed(NORM_NEG))
      else $error("normal component beyond unit");

endmodule
